>>> sv/lfps_pkg.sv
package lfps_pkg;

  localparam int unsigned GAIN_W             = 16;
  localparam int unsigned SPEED_W            = 8;
  localparam int unsigned ERR_W              = 3;
  localparam int unsigned DERIV_W            = 4;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 16;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;

  // digit term range is -9..9, running high part stays within that too
  localparam int unsigned ACC_HI_W = 6;
  localparam int unsigned SUM_W    = ACC_HI_W + GAIN_W;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd8192;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd82;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd20;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 8'd35;

  typedef enum logic [1:0] {
    MODE_STEER   = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_LOST    = 2'd2
  } drive_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_BASE_SPEED  = 3'd2,
    REG_SPEED_LIMIT = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic busy;
    logic last;
  } mac_stat_t;

  // weighted sensor position, truncated toward zero
  function automatic logic signed [ERR_W-1:0] line_pos(input logic [3:0] bits);
    logic signed [ERR_W-1:0] pos;
    case (bits)
      4'd1:    pos = -3'sd3;
      4'd2:    pos = -3'sd1;
      4'd3:    pos = -3'sd2;
      4'd4:    pos = 3'sd1;
      4'd5:    pos = -3'sd1;
      4'd7:    pos = -3'sd1;
      4'd8:    pos = 3'sd3;
      4'd10:   pos = 3'sd1;
      4'd12:   pos = 3'sd2;
      4'd14:   pos = 3'sd1;
      default: pos = 3'sd0;
    endcase
    return pos;
  endfunction

endpackage

>>> sv/lfps_serial_mac.sv
module lfps_serial_mac
  import lfps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [GAIN_W-1:0]        prop_gain_i,
  input  logic [GAIN_W-1:0]        deriv_gain_i,
  input  logic signed [ERR_W-1:0]  err_i,
  input  logic signed [DERIV_W-1:0] deriv_i,
  output mac_stat_t                stat_o,
  output logic signed [SUM_W-1:0]  sum_o
);

  localparam int unsigned CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(GAIN_W - 1);

  logic                       busy_q, busy_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [GAIN_W-1:0]          p_sr_q, p_sr_d;
  logic [GAIN_W-1:0]          d_sr_q, d_sr_d;
  logic signed [ERR_W-1:0]    err_q, err_d;
  logic signed [DERIV_W-1:0]  deriv_q, deriv_d;
  logic signed [ACC_HI_W-1:0] hi_q, hi_d;
  logic [GAIN_W-1:0]          lo_q, lo_d;

  logic signed [ACC_HI_W-1:0] term;
  logic signed [ACC_HI_W-1:0] tmp;

  // one gain bit of each gain per cycle, lsb first
  always_comb begin
    term = '0;
    if (p_sr_q[0]) begin
      term = term + ACC_HI_W'(err_q);
    end
    if (d_sr_q[0]) begin
      term = term + ACC_HI_W'(deriv_q);
    end
    tmp = hi_q + term;
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    p_sr_d  = p_sr_q;
    d_sr_d  = d_sr_q;
    err_d   = err_q;
    deriv_d = deriv_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      p_sr_d  = prop_gain_i;
      d_sr_d  = deriv_gain_i;
      err_d   = err_i;
      deriv_d = deriv_i;
      hi_d    = '0;
      lo_d    = '0;
    end else if (busy_q) begin
      p_sr_d = p_sr_q >> 1;
      d_sr_d = d_sr_q >> 1;
      lo_d   = {tmp[0], lo_q[GAIN_W-1:1]};
      hi_d   = tmp >>> 1;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_sr_q  <= p_sr_d;
    d_sr_q  <= d_sr_d;
    err_q   <= err_d;
    deriv_q <= deriv_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign stat_o = '{busy: busy_q, last: busy_q && (cnt_q == CntLast)};
  assign sum_o  = {hi_q, lo_q};

endmodule

>>> sv/line_follow_pd_steering.sv
// a steering transaction passes through the bit-serial gain multiply, scale and clamp
// before the output load; when stopped or line lost it goes straight to the output load
// one transaction at a time: a new one is accepted only in idle, after the previous
// result has been loaded into the output register; that load waits while the output is full
// reset: gains, speeds and limit to their defaults, previous error to 0, output empty
module line_follow_pd_steering
  import lfps_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            sensor_bits_i,
  input  logic                  run_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SPEED_W-1:0]    left_speed_o,
  output logic [SPEED_W-1:0]    right_speed_o,
  output logic [1:0]            drive_mode_o,
  output logic signed [ERR_W-1:0] line_error_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SPD_W = SUM_W + 1;
  localparam logic signed [SUM_W-1:0] RoundBias = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE,
    ST_CLAMP,
    ST_HOLD
  } state_e;

  logic [GAIN_W-1:0]  prop_gain_q, deriv_gain_q;
  logic [SPEED_W-1:0] base_speed_q, speed_limit_q;
  logic signed [ERR_W-1:0] prev_err_q;

  state_e state_q;
  logic signed [SUM_W-1:0]  corr_q;
  logic [SPEED_W-1:0]       res_left_q, res_right_q;
  logic [1:0]               res_mode_q;
  logic signed [ERR_W-1:0]  res_err_q;
  logic                     out_valid_q;
  logic [SPEED_W-1:0]       out_left_q, out_right_q;
  logic [1:0]               out_mode_q;
  logic signed [ERR_W-1:0]  out_err_q;

  logic                      in_fire;
  logic                      found;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [DERIV_W-1:0] deriv_in;
  logic                      mac_start;
  mac_stat_t                 mac_stat;
  logic signed [SUM_W-1:0]   mac_sum;
  logic signed [SUM_W-1:0]   scaled;
  logic signed [SPD_W-1:0]   left_v, right_v;
  logic                      out_free;

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SPD_W-1:0] v,
                                                     input logic [SPEED_W-1:0] lim);
    logic [SPEED_W-1:0] r;
    if (v > $signed({{(SPD_W-SPEED_W){1'b0}}, lim})) begin
      r = lim;
    end else if (v < 0) begin
      r = '0;
    end else begin
      r = v[SPEED_W-1:0];
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PROP_GAIN_RST;
      deriv_gain_q  <= DERIV_GAIN_RST;
      base_speed_q  <= BASE_SPEED_RST;
      speed_limit_q <= SPEED_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
        REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i;
        REG_BASE_SPEED:  base_speed_q  <= cfg_data_i[SPEED_W-1:0];
        REG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign found      = |sensor_bits_i;
  assign err_in     = line_pos(sensor_bits_i);
  assign deriv_in   = DERIV_W'(err_in) - DERIV_W'(prev_err_q);
  assign mac_start  = in_fire && run_i && found;

  lfps_serial_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (mac_start),
    .prop_gain_i  (prop_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .err_i        (err_in),
    .deriv_i      (deriv_in),
    .stat_o       (mac_stat),
    .sum_o        (mac_sum)
  );

  // truncate toward zero: bias negative sums before the arithmetic shift
  assign scaled  = (mac_sum + (mac_sum[SUM_W-1] ? RoundBias : SUM_W'(0))) >>> GAIN_FRAC_BITS;
  assign left_v  = $signed({{(SPD_W-SPEED_W){1'b0}}, base_speed_q})
                 - $signed({corr_q[SUM_W-1], corr_q});
  assign right_v = $signed({{(SPD_W-SPEED_W){1'b0}}, base_speed_q})
                 + $signed({corr_q[SUM_W-1], corr_q});
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_err_q  <= '0;
      corr_q      <= '0;
      res_left_q  <= '0;
      res_right_q <= '0;
      res_mode_q  <= MODE_STEER;
      res_err_q   <= '0;
      out_valid_q <= 1'b0;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_mode_q  <= MODE_STEER;
      out_err_q   <= '0;
    end else begin
      // in the hold state the output register is reloaded instead
      if (out_valid_q && out_ready_i && (state_q != ST_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            res_left_q  <= '0;
            res_right_q <= '0;
            res_err_q   <= '0;
            if (!run_i) begin
              res_mode_q <= MODE_STOPPED;
              state_q    <= ST_HOLD;
            end else if (!found) begin
              res_mode_q <= MODE_LOST;
              state_q    <= ST_HOLD;
            end else begin
              res_mode_q <= MODE_STEER;
              res_err_q  <= err_in;
              prev_err_q <= err_in;
              state_q    <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          if (mac_stat.last) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          corr_q  <= scaled;
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          res_left_q  <= clamp_speed(left_v, speed_limit_q);
          res_right_q <= clamp_speed(right_v, speed_limit_q);
          state_q     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_left_q  <= res_left_q;
            out_right_q <= res_right_q;
            out_mode_q  <= res_mode_q;
            out_err_q   <= res_err_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = out_left_q;
  assign right_speed_o = out_right_q;
  assign drive_mode_o  = out_mode_q;
  assign line_error_o  = out_err_q;

  a_mac_only_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_stat.busy |-> (state_q == ST_MAC))
    else $error("multiplier busy outside its state");

  a_mac_runs_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> mac_stat.busy)
    else $error("waiting on an idle multiplier");

  a_idle_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (drive_mode_o != MODE_STEER)) |->
      (left_speed_o == '0 && right_speed_o == '0 && line_error_o == '0))
    else $error("speeds not zero while stopped or lost");

  a_speed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_speed_o <= speed_limit_q && right_speed_o <= speed_limit_q))
    else $error("speed above limit");

  a_steer_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && run_i && found) |=> (state_q == ST_MAC && mac_stat.busy))
    else $error("steering transaction did not start the multiplier");

endmodule

>>> bench/lfps_steer_checker.sv
`timescale 1ns / 1ps

module lfps_steer_checker
  import lfps_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [3:0]              sensor_bits_i,
  input  logic                    run_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [SPEED_W-1:0]      left_speed_i,
  input  logic [SPEED_W-1:0]      right_speed_i,
  input  logic [1:0]              drive_mode_i,
  input  logic signed [ERR_W-1:0] line_error_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                      mismatch_count_o,
  output int                      results_pending_o
);

  typedef struct packed {
    logic [SPEED_W-1:0]      left;
    logic [SPEED_W-1:0]      right;
    drive_mode_e             mode;
    logic signed [ERR_W-1:0] err;
  } steer_result_t;

  steer_result_t      expected_q[$];
  logic [GAIN_W-1:0]  kp;
  logic [GAIN_W-1:0]  kd;
  logic [SPEED_W-1:0] base_spd;
  logic [SPEED_W-1:0] speed_lim;
  int                 last_err;
  int                 result_no;
  int                 mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    // keep the log short on a badly broken build
    if (mismatches <= 40) begin
      $display("[%0t] result %0d: %s got %0d want %0d", $time, result_no, what, got, want);
    end
  endtask

  function automatic logic [SPEED_W-1:0] clamp_speed(input longint v);
    longint lim;
    lim = longint'(speed_lim);
    if (v > lim) v = lim;
    if (v < 0) v = 0;
    return v[SPEED_W-1:0];
  endfunction

  function automatic steer_result_t predict_steering(input logic [3:0] bits, input logic run);
    steer_result_t r;
    int            weight_sum;
    int            hits;
    int            pos;
    int            slope;
    longint        acc;
    longint        mag;
    longint        corr;
    r.left  = '0;
    r.right = '0;
    r.mode  = MODE_STOPPED;
    r.err   = '0;
    if (!run) return r;
    weight_sum = 0;
    hits       = 0;
    if (bits[0]) begin
      weight_sum -= 3;
      hits++;
    end
    if (bits[1]) begin
      weight_sum -= 1;
      hits++;
    end
    if (bits[2]) begin
      weight_sum += 1;
      hits++;
    end
    if (bits[3]) begin
      weight_sum += 3;
      hits++;
    end
    if (hits == 0) begin
      r.mode = MODE_LOST;
      return r;
    end
    // integer division truncates toward zero
    pos      = weight_sum / hits;
    slope    = pos - last_err;
    last_err = pos;
    acc  = longint'(kp) * pos + longint'(kd) * slope;
    mag  = (acc < 0) ? -acc : acc;
    mag  = mag >> GAIN_FRAC_BITS_DEF;
    corr = (acc < 0) ? -mag : mag;
    r.left  = clamp_speed(longint'(base_spd) - corr);
    r.right = clamp_speed(longint'(base_spd) + corr);
    r.mode  = MODE_STEER;
    r.err   = pos[ERR_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    steer_result_t want;
    if (!rst_ni) begin
      kp        = PROP_GAIN_RST;
      kd        = DERIV_GAIN_RST;
      base_spd  = BASE_SPEED_RST;
      speed_lim = SPEED_LIMIT_RST;
      last_err  = 0;
      result_no = 0;
      expected_q.delete();
      results_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PROP_GAIN:   kp = cfg_data_i;
          REG_DERIV_GAIN:  kd = cfg_data_i;
          REG_BASE_SPEED:  base_spd = cfg_data_i[SPEED_W-1:0];
          REG_SPEED_LIMIT: speed_lim = cfg_data_i[SPEED_W-1:0];
          default: ;
        endcase
      end
      // retire before pushing so an early result cannot match its own transaction
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, mode", int'(drive_mode_i), -1);
        end else begin
          want = expected_q.pop_front();
          if (left_speed_i !== want.left)
            report_mismatch("left_speed", int'(left_speed_i), int'(want.left));
          if (right_speed_i !== want.right)
            report_mismatch("right_speed", int'(right_speed_i), int'(want.right));
          if (drive_mode_i !== want.mode)
            report_mismatch("drive_mode", int'(drive_mode_i), int'(want.mode));
          if (line_error_i !== want.err)
            report_mismatch("line_error", int'(line_error_i), int'(want.err));
        end
        result_no++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_steering(sensor_bits_i, run_i));
      end
      results_pending_o <= expected_q.size();
    end
  end

endmodule

>>> bench/tb_line_follow_pd_steering.sv
`timescale 1ns / 1ps

module tb_line_follow_pd_steering;
  import lfps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int                   HOLD_CYCLES  = 400;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_RHYTHM
  } ready_style_e;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic [3:0]              sensor_bits_i = '0;
  logic                    run_i         = 1'b0;
  logic                    out_ready_i   = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic                    cfg_ready_o;
  logic [SPEED_W-1:0]      left_speed_o;
  logic [SPEED_W-1:0]      right_speed_o;
  logic [1:0]              drive_mode_o;
  logic signed [ERR_W-1:0] line_error_o;

  int   mismatch_count;
  int   results_pending;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;
  int   burst_left = 0;

  line_follow_pd_steering dut (.*);

  lfps_steer_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .sensor_bits_i     (sensor_bits_i),
    .run_i             (run_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .left_speed_i      (left_speed_o),
    .right_speed_i     (right_speed_o),
    .drive_mode_i      (drive_mode_o),
    .line_error_i      (line_error_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin : watchdog
    #2000000;
    $display("line_follow_pd_steering verification failed");
    $finish;
  end

  // valid stays high through a burst, so it is only lowered for a gap
  task automatic send_item(input logic [3:0] bits, input logic run);
    in_valid_i    <= 1'b1;
    sensor_bits_i <= bits;
    run_i         <= run;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic send_random(input int n);
    int          pick;
    logic [3:0]  bits;
    logic        run;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      run  = (pick > 1);
      if (pick == 0)
        bits = 4'($urandom_range(0, 15));
      else if (pick == 2 || pick == 3)
        bits = 4'd0;
      else
        bits = 4'($urandom_range(1, 15));
      send_item(bits, run);
    end
  endtask

  // hold the sender until every outstanding transaction has come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] p_gain, input logic [CFG_DATA_W-1:0] d_gain,
                          input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] lim,
                          input logic [CFG_IDX_W-1:0] spare_idx);
    write_reg(REG_PROP_GAIN, p_gain);
    write_reg(REG_DERIV_GAIN, d_gain);
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_SPEED_LIMIT, lim);
    // writes to an unused index must leave everything alone
    write_reg(spare_idx, 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : receiver
    int           stretch;
    int           beat;
    ready_style_e style;
    beat = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        stretch = $urandom_range(4, 60);
        style   = ready_style_e'($urandom_range(0, 3));
        repeat (stretch) begin
          case (style)
            READY_ALWAYS: out_ready_i <= 1'b1;
            READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
            READY_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
            default:      out_ready_i <= (beat % 5 == 4);
          endcase
          beat++;
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset values of the registers: stopped beats line lost, full swing of error
    send_item(4'd0, 1'b0);
    send_item(4'd15, 1'b0);
    send_item(4'd0, 1'b1);
    send_item(4'd1, 1'b1);
    send_item(4'd8, 1'b1);
    send_item(4'd6, 1'b0);
    send_item(4'd0, 1'b1);
    send_item(4'd1, 1'b1);
    for (int b = 2; b < 16; b++) send_item(4'(b), 1'b1);
    send_item(4'd8, 1'b1);
    send_random(70);
    wait_idle();

    set_regs(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h00FF, REG_SPARE_HI);
    // receiver goes quiet for a long stretch while items keep coming
    hold_req <= 1'b1;
    send_random(70);
    wait_idle();

    set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, REG_SPARE_LO);
    send_random(40);
    wait_idle();

    // upper data bits are dropped, so the limit ends up zero
    set_regs(16'($urandom), 16'($urandom), 16'hFFC8, 16'hFF00, REG_SPARE_HI);
    send_random(40);
    wait_idle();

    set_regs(16'h1000, 16'h0800, 16'd200, 16'd50, REG_SPARE_LO);
    send_random(60);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      set_regs((p < 2) ? 16'($urandom_range(0, 16'h2FFF)) : 16'($urandom),
               (p < 2) ? 16'($urandom_range(0, 16'h2FFF)) : 16'($urandom),
               16'($urandom), 16'($urandom), p[0] ? REG_SPARE_HI : REG_SPARE_LO);
      send_random(70);
      wait_idle();
    end

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("line_follow_pd_steering verification clean");
    end else begin
      $display("line_follow_pd_steering verification failed");
    end
    $finish;
  end

endmodule
